// ===== src/linear_to_tiled_region_address_top_assert.svh =====
// assertion macros for the linear to tiled region address block
// used by the top level only; needs i_clk and i_rst_n in scope
`ifndef LINEAR_TO_TILED_REGION_ADDRESS_TOP_ASSERT_SVH
`define LINEAR_TO_TILED_REGION_ADDRESS_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define L2T_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define L2T_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define L2T_ASSERT(label, prop, msg)
`define L2T_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== src/l2t_pkg.sv =====
// shared constants, types and the sub-region lookup for the tiled address block
// no dependencies
package l2t_pkg;

    localparam int TILE_ROW_BYTES = 4;
    localparam int TILE_ROWS      = 8;
    localparam int TILE_BYTES     = TILE_ROW_BYTES * TILE_ROWS;
    localparam int REGION_COUNT   = 6;
    localparam int FRAME_TILES    = 100;
    localparam int FRAME_BYTES    = FRAME_TILES * TILE_BYTES;

    localparam int IDX_W     = 12;
    localparam int OFF_W     = 21;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    localparam int BYTE_SH = $clog2(TILE_ROW_BYTES);
    localparam int ROW_SH  = $clog2(TILE_ROWS);
    localparam int TILE_SH = BYTE_SH + ROW_SH;
    localparam int TILE_W  = IDX_W - TILE_SH;

    localparam int COORD_W = 4;
    localparam int POS_W   = CFG_W + 1;
    localparam int SROW_W  = POS_W + ROW_SH;
    localparam int XB_W    = POS_W + BYTE_SH;
    localparam int LINE_W  = CFG_W + BYTE_SH;
    localparam int PROD_W  = SROW_W + LINE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHEET_W = 3'd0,
        CFG_SHEET_H = 3'd1,
        CFG_RECT_X  = 3'd2,
        CFG_RECT_Y  = 3'd3,
        CFG_RECT_W  = 3'd4,
        CFG_RECT_H  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] sheet_w;
        logic [CFG_W-1:0] sheet_h;
        logic [CFG_W-1:0] rect_x;
        logic [CFG_W-1:0] rect_y;
        logic [CFG_W-1:0] rect_w;
        logic [CFG_W-1:0] rect_h;
    } t_cfg;

    // decoded word between the decode and address stages
    typedef struct packed {
        logic              ok;
        logic [SROW_W-1:0] srow;
        logic [XB_W-1:0]   xbyte;
    } t_dec;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [1:0]         wsh;
        logic [TILE_W-1:0]  base;
        logic [TILE_W-1:0]  count;
    } t_region;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_hit;

    // x, y, width, log2 width, first tile, tile count
    localparam t_region REGION_TABLE [REGION_COUNT] = '{
        '{4'h0, 4'h0, 4'h8, 2'd3, 7'd0,  7'd64},
        '{4'h8, 4'h0, 4'h2, 2'd1, 7'd64, 7'd8},
        '{4'h8, 4'h4, 4'h2, 2'd1, 7'd72, 7'd8},
        '{4'h0, 4'h8, 4'h4, 2'd2, 7'd80, 7'd8},
        '{4'h4, 4'h8, 4'h4, 2'd2, 7'd88, 7'd8},
        '{4'h8, 4'h8, 4'h2, 2'd1, 7'd96, 7'd4}
    };

    // rectangle tile coordinates of a frame tile
    function automatic t_hit region_lookup(input logic [TILE_W-1:0] tile);
        t_hit              hit;
        logic [TILE_W-1:0] k;
        logic [TILE_W-1:0] mask;
        logic [TILE_W:0]   top;
        hit = '0;
        for (int i = 0; i < REGION_COUNT; i++) begin
            k    = tile - REGION_TABLE[i].base;
            mask = TILE_W'(REGION_TABLE[i].w) - TILE_W'(1);
            top  = {1'b0, REGION_TABLE[i].base} + {1'b0, REGION_TABLE[i].count};
            if (!hit.found && tile >= REGION_TABLE[i].base && {1'b0, tile} < top) begin
                hit.found = 1'b1;
                hit.col   = REGION_TABLE[i].x + COORD_W'(k & mask);
                hit.row   = REGION_TABLE[i].y + COORD_W'(k >> REGION_TABLE[i].wsh);
            end
        end
        return hit;
    endfunction

endpackage

// ===== src/l2t_in_if.sv =====
// input channel: one destination index word per handshake
// depends on l2t_pkg
interface l2t_in_if;
    import l2t_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] dest_index;

    modport source (output valid, output dest_index, input ready);
    modport sink   (input valid, input dest_index, output ready);
endinterface

// ===== src/l2t_out_if.sv =====
// result channel: source offset and range flag per handshake
// depends on l2t_pkg
interface l2t_out_if;
    import l2t_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] source_offset;
    logic             in_range;

    modport source (output valid, output source_offset, output in_range, input ready);
    modport sink   (input valid, input source_offset, input in_range, output ready);
endinterface

// ===== src/l2t_cfg.sv =====
// configuration register file written through the plain write port
// depends on l2t_pkg
module l2t_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [l2t_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [l2t_pkg::CFG_W-1:0]     i_data,
    output l2t_pkg::t_cfg                 o_cfg
);
    import l2t_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                CFG_SHEET_W: n_cfg.sheet_w = i_data;
                CFG_SHEET_H: n_cfg.sheet_h = i_data;
                CFG_RECT_X:  n_cfg.rect_x  = i_data;
                CFG_RECT_Y:  n_cfg.rect_y  = i_data;
                CFG_RECT_W:  n_cfg.rect_w  = i_data;
                CFG_RECT_H:  n_cfg.rect_h  = i_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sheet_w <= CFG_W'(16);
            r_cfg.sheet_h <= CFG_W'(16);
            r_cfg.rect_x  <= '0;
            r_cfg.rect_y  <= '0;
            r_cfg.rect_w  <= CFG_W'(10);
            r_cfg.rect_h  <= CFG_W'(10);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== src/l2t_decode.sv =====
// frame index to sheet pixel row and byte column, with all range checks
// depends on l2t_pkg
module l2t_decode (
    input  logic [l2t_pkg::IDX_W-1:0] i_dest_index,
    input  l2t_pkg::t_cfg             i_cfg,
    output l2t_pkg::t_dec             o_dec
);
    import l2t_pkg::*;

    logic [TILE_W-1:0]  tile;
    logic [ROW_SH-1:0]  prow;
    logic [BYTE_SH-1:0] pbyte;
    t_hit               hit;
    logic               in_frame;
    logic [POS_W-1:0]   x_end;
    logic [POS_W-1:0]   y_end;
    logic               rect_fits;
    logic               tile_fits;
    logic [POS_W-1:0]   sheet_y;
    logic [POS_W-1:0]   sheet_x;

    assign tile  = i_dest_index[IDX_W-1:TILE_SH];
    assign prow  = i_dest_index[TILE_SH-1:BYTE_SH];
    assign pbyte = i_dest_index[BYTE_SH-1:0];
    assign hit   = region_lookup(tile);

    assign in_frame  = i_dest_index < IDX_W'(FRAME_BYTES);
    assign x_end     = {1'b0, i_cfg.rect_x} + {1'b0, i_cfg.rect_w};
    assign y_end     = {1'b0, i_cfg.rect_y} + {1'b0, i_cfg.rect_h};
    assign rect_fits = (x_end <= {1'b0, i_cfg.sheet_w}) && (y_end <= {1'b0, i_cfg.sheet_h});
    assign tile_fits = (CFG_W'(hit.col) < i_cfg.rect_w) && (CFG_W'(hit.row) < i_cfg.rect_h);

    assign sheet_y = {1'b0, i_cfg.rect_y} + POS_W'(hit.row);
    assign sheet_x = {1'b0, i_cfg.rect_x} + POS_W'(hit.col);

    assign o_dec.ok    = in_frame && hit.found && rect_fits && tile_fits;
    assign o_dec.srow  = {sheet_y, prow};
    assign o_dec.xbyte = {sheet_x, pbyte};
endmodule

// ===== src/l2t_addr.sv =====
// sheet byte offset: pixel row times line pitch plus byte column
// depends on l2t_pkg
module l2t_addr (
    input  l2t_pkg::t_dec             i_dec,
    input  l2t_pkg::t_cfg             i_cfg,
    output logic [l2t_pkg::OFF_W-1:0] o_offset
);
    import l2t_pkg::*;

    logic [LINE_W-1:0] line_bytes;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;

    assign line_bytes = {i_cfg.sheet_w, {BYTE_SH{1'b0}}};
    assign prod       = PROD_W'(i_dec.srow) * PROD_W'(line_bytes);
    assign sum        = prod + PROD_W'(i_dec.xbyte);
    // offset wraps to the low bits of the exact sum
    assign o_offset   = i_dec.ok ? OFF_W'(sum) : '0;
endmodule

// ===== src/linear_to_tiled_region_address_top.sv =====
// Linear to tiled region address generator. Each destination index word maps to one result
// word: the byte offset in a linear 4bpp sheet and an in-range flag (offset zero when out of
// range). One word is accepted every cycle while results are taken; its result passes the
// decode and result registers and is held until taken. Three register stages (input, decode,
// result) each move when empty or when the stage after them moves, so throughput is one word
// per cycle while results are taken; with the result stalled, up to two more words are taken
// before the input stalls. The 12 x 10 bit pitch multiply in the address stage is the longest
// path. Configuration writes take effect at once, so write them with nothing in flight.
// depends on l2t_pkg, l2t_in_if, l2t_out_if, l2t_cfg, l2t_decode, l2t_addr
`include "linear_to_tiled_region_address_top_assert.svh"
module linear_to_tiled_region_address_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [l2t_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [l2t_pkg::CFG_W-1:0]     i_cfg_data,
    l2t_in_if.sink                        i_in,
    l2t_out_if.source                     o_out
);
    import l2t_pkg::*;

    t_cfg             cfg;
    t_dec             dec;
    logic [OFF_W-1:0] offset;

    logic             r_in_v;
    logic [IDX_W-1:0] r_in_idx;
    logic             r_mid_v;
    t_dec             r_mid;
    logic             r_out_v;
    logic [OFF_W-1:0] r_out_off;
    logic             r_out_rng;

    logic en_out;
    logic en_mid;
    logic en_in;

    l2t_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    l2t_decode u_decode (
        .i_dest_index (r_in_idx),
        .i_cfg        (cfg),
        .o_dec        (dec)
    );

    l2t_addr u_addr (
        .i_dec    (r_mid),
        .i_cfg    (cfg),
        .o_offset (offset)
    );

    // a stage moves when it is empty or the one after it moves
    assign en_out = !r_out_v || o_out.ready;
    assign en_mid = !r_mid_v || en_out;
    assign en_in  = !r_in_v || en_mid;

    assign i_in.ready = en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_v <= i_in.valid;
            end
            if (en_mid) begin
                r_mid_v <= r_in_v;
            end
            if (en_out) begin
                r_out_v <= r_mid_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_idx <= i_in.dest_index;
        end
        if (en_mid) begin
            r_mid <= dec;
        end
        if (en_out) begin
            r_out_off <= offset;
            r_out_rng <= r_mid.ok;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.source_offset = r_out_off;
    assign o_out.in_range      = r_out_rng;

    `L2T_ASSERT(a_zero_when_out, o_out.valid && !o_out.in_range |-> o_out.source_offset == '0, "out of range result carries a nonzero offset")
    `L2T_ASSERT(a_past_frame, r_in_v && en_mid && (r_in_idx >= IDX_W'(FRAME_BYTES)) |=> !r_mid.ok, "index past the frame decoded as in range")
    `L2T_ASSERT(a_full_stall, r_in_v && r_mid_v && r_out_v && !o_out.ready |-> !i_in.ready, "word taken while every stage is stalled")
    `L2T_ASSERT_RST(a_reset_empty, $past(!i_rst_n) |-> !o_out.valid && !r_mid_v && !r_in_v, "pipeline not empty after reset")
endmodule

// ===== tb/linear_to_tiled_region_address_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the linear to tiled region address block: random and edge
// destination indexes under several register settings, results checked in order
// depends on l2t_pkg, l2t_in_if, l2t_out_if and linear_to_tiled_region_address_top
module linear_to_tiled_region_address_top_tb;
    import l2t_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_WORDS  = 150;
    localparam int REPORT_LIMIT = 10;

    // sub-region placement in rectangle tiles, in frame order
    localparam int SUB_X [REGION_COUNT] = '{0, 8, 8, 0, 4, 8};
    localparam int SUB_Y [REGION_COUNT] = '{0, 0, 4, 8, 8, 8};
    localparam int SUB_W [REGION_COUNT] = '{8, 2, 2, 4, 4, 2};
    localparam int SUB_H [REGION_COUNT] = '{8, 4, 4, 2, 2, 2};

    // frame start, sub-region seams, last in-frame byte and the words past the frame
    localparam logic [IDX_W-1:0] EDGE_INDEXES [18] = '{
        12'd0, 12'd3, 12'd31, 12'd1234, 12'd2047, 12'd2048, 12'd2303, 12'd2304,
        12'd2559, 12'd2560, 12'd2815, 12'd2816, 12'd3071, 12'd3072, 12'd3199,
        12'd3200, 12'd3201, 12'd4095
    };

    typedef struct packed {
        logic [OFF_W-1:0] source_offset;
        logic             in_range;
    } t_addr_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    l2t_in_if  in_ch ();
    l2t_out_if out_ch ();

    linear_to_tiled_region_address_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_cfg             shadow_cfg;
    logic [IDX_W-1:0] index_pending [$];
    t_addr_word       offsets_due [$];
    bit               steady;
    int               fail_count;
    int               cycle_count;

    always #2 i_clk = ~i_clk;

    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < 9);
    endfunction

    // sheet byte that feeds one byte of the tiled frame
    function automatic t_addr_word predict_offset(input logic [IDX_W-1:0] idx);
        int         tile, inner, prow, pbyte, first, k, col, row;
        int         sw, sh, rx, ry, rw, rh;
        bit         hit;
        longint     srow, off;
        t_addr_word r;
        tile  = int'(idx) / TILE_BYTES;
        inner = int'(idx) % TILE_BYTES;
        prow  = inner / TILE_ROW_BYTES;
        pbyte = inner % TILE_ROW_BYTES;
        sw = int'(shadow_cfg.sheet_w);
        sh = int'(shadow_cfg.sheet_h);
        rx = int'(shadow_cfg.rect_x);
        ry = int'(shadow_cfg.rect_y);
        rw = int'(shadow_cfg.rect_w);
        rh = int'(shadow_cfg.rect_h);
        hit   = 1'b0;
        first = 0;
        col   = 0;
        row   = 0;
        for (int i = 0; i < REGION_COUNT; i++) begin
            if (!hit && tile < first + SUB_W[i] * SUB_H[i]) begin
                k   = tile - first;
                col = SUB_X[i] + k % SUB_W[i];
                row = SUB_Y[i] + k / SUB_W[i];
                hit = 1'b1;
            end
            first += SUB_W[i] * SUB_H[i];
        end
        r = '0;
        if (hit && rx + rw <= sw && ry + rh <= sh && col < rw && row < rh) begin
            srow = longint'(ry + row) * TILE_ROWS + prow;
            off  = srow * longint'(sw) * TILE_ROW_BYTES + longint'(rx + col) * TILE_ROW_BYTES
                   + pbyte;
            r.source_offset = OFF_W'(off);
            r.in_range      = 1'b1;
        end
        return r;
    endfunction

    // rectangle that fits the sheet, so most words come back in range
    function automatic t_cfg fitted_settings();
        t_cfg c;
        c.sheet_w = CFG_W'($urandom_range(10, 255));
        c.sheet_h = CFG_W'($urandom_range(10, 255));
        c.rect_w  = CFG_W'($urandom_range(10, c.sheet_w));
        c.rect_h  = CFG_W'($urandom_range(10, c.sheet_h));
        c.rect_x  = CFG_W'($urandom_range(0, c.sheet_w - c.rect_w));
        c.rect_y  = CFG_W'($urandom_range(0, c.sheet_h - c.rect_h));
        return c;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_SHEET_W: shadow_cfg.sheet_w = value;
            CFG_SHEET_H: shadow_cfg.sheet_h = value;
            CFG_RECT_X:  shadow_cfg.rect_x  = value;
            CFG_RECT_Y:  shadow_cfg.rect_y  = value;
            CFG_RECT_W:  shadow_cfg.rect_w  = value;
            CFG_RECT_H:  shadow_cfg.rect_h  = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_SHEET_W, c.sheet_w);
        write_reg(CFG_SHEET_H, c.sheet_h);
        write_reg(CFG_RECT_X, c.rect_x);
        write_reg(CFG_RECT_Y, c.rect_y);
        write_reg(CFG_RECT_W, c.rect_w);
        write_reg(CFG_RECT_H, c.rect_h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random_words(input int count);
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(99) < 85) begin
                index_pending.push_back(IDX_W'($urandom_range(0, FRAME_BYTES - 1)));
            end else begin
                index_pending.push_back(IDX_W'($urandom_range(FRAME_BYTES, 4095)));
            end
        end
    endtask

    // sampled on the falling edge so every update of the rising edge has landed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (index_pending.size() != 0 || in_ch.valid || offsets_due.size() != 0);
    endtask

    // index driver; the expected word is worked out when the index is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                offsets_due.push_back(predict_offset(in_ch.dest_index));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (index_pending.size() != 0 && !idle_roll()) begin
                    in_ch.valid      <= 1'b1;
                    in_ch.dest_index <= index_pending.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_addr_word want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !idle_roll();
            if (out_ch.valid && out_ch.ready) begin
                if (offsets_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected word: offset %0d in_range %0b",
                                 out_ch.source_offset, out_ch.in_range);
                    end
                end else begin
                    want = offsets_due.pop_front();
                    if (out_ch.source_offset !== want.source_offset
                            || out_ch.in_range !== want.in_range) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("mismatch: offset %0d in_range %0b, expected %0d %0b",
                                     out_ch.source_offset, out_ch.in_range,
                                     want.source_offset, want.in_range);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_cfg setting;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SHEET_W;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.dest_index = '0;
        out_ch.ready     = 1'b0;
        steady           = 1'b0;
        fail_count       = 0;
        cycle_count      = 0;
        shadow_cfg = '{sheet_w: 8'd16, sheet_h: 8'd16, rect_x: 8'd0, rect_y: 8'd0,
                       rect_w: 8'd10, rect_h: 8'd10};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first, edge indexes then random words
        foreach (EDGE_INDEXES[j]) index_pending.push_back(EDGE_INDEXES[j]);
        queue_random_words(PHASE_WORDS);
        wait_drained();

        for (int p = 1; p < PHASE_COUNT; p++) begin
            case (p)
                // largest sheet, rectangle in the far corner
                1: setting = '{sheet_w: 8'd255, sheet_h: 8'd255, rect_x: 8'd245,
                               rect_y: 8'd245, rect_w: 8'd10, rect_h: 8'd10};
                // rectangle covering the whole sheet
                2: setting = '{sheet_w: 8'd255, sheet_h: 8'd255, rect_x: 8'd0,
                               rect_y: 8'd0, rect_w: 8'd255, rect_h: 8'd255};
                // rectangle smaller than the frame
                3: setting = '{sheet_w: 8'd16, sheet_h: 8'd16, rect_x: 8'd3,
                               rect_y: 8'd2, rect_w: 8'd5, rect_h: 8'd9};
                // rectangle past the right edge of the sheet
                4: setting = '{sheet_w: 8'd20, sheet_h: 8'd20, rect_x: 8'd11,
                               rect_y: 8'd0, rect_w: 8'd10, rect_h: 8'd10};
                // rectangle past the bottom edge
                5: setting = '{sheet_w: 8'd30, sheet_h: 8'd12, rect_x: 8'd4,
                               rect_y: 8'd3, rect_w: 8'd10, rect_h: 8'd10};
                // all registers zero
                6: setting = '0;
                // anything at all
                PHASE_COUNT - 1: setting = t_cfg'({$urandom, $urandom});
                default: setting = fitted_settings();
            endcase
            steady = (p == 2);
            load_settings(setting);
            queue_random_words(PHASE_WORDS);
            wait_drained();
        end
        steady = 1'b0;

        repeat (8) @(posedge i_clk);
        if (offsets_due.size() != 0) begin
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
